### rtl/core/word_wrap_tile_writer_assert.svh
// ----------------------------------------------------------------------------
// Word wrap tile writer - assertion macros
// Concurrent assertion wrappers; they expand to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef WORD_WRAP_TILE_WRITER_ASSERT_SVH
`define WORD_WRAP_TILE_WRITER_ASSERT_SVH
`ifndef SYNTHESIS
// check prop on every edge outside reset
`define WWTW_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("wwtw assertion failed");
// check prop on the edge that follows a reset cycle
`define WWTW_ASSERT_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) rst |=> prop) \
      else $error("wwtw reset assertion failed");
`else
`define WWTW_ASSERT(label, clk, rst, prop)
`define WWTW_ASSERT_RST(label, clk, rst, prop)
`endif
`endif

### rtl/core/wwtw_pkg.sv
// ----------------------------------------------------------------------------
// Word wrap tile writer - package
// Widths, codes, command/status bundles and character helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package wwtw_pkg;

   localparam int MAX_WORD      = 64;
   localparam int PRINT_COLUMNS = 80;

   localparam int CHAR_W     = 8;
   localparam int COL_W      = 8;
   localparam int ROW_W      = 8;
   localparam int IDX_W      = $clog2(MAX_WORD);
   localparam int LEN_W      = $clog2(MAX_WORD + 1);
   localparam int FIT_W      = COL_W + 1;
   localparam int ADDR_LO_W  = 16;
   localparam int ADDR_W     = ADDR_LO_W + 1;
   localparam int BASE_SHIFT = 9;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam int BASE_W     = 8;
   localparam int WRAP_W     = 7;
   localparam int COLOR_W    = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_MAP_BASE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WRAP_WIDTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TEXT_COLOR = 2'd2;

   localparam logic [BASE_W-1:0]  MAP_BASE_RST   = 8'd0;
   localparam logic [WRAP_W-1:0]  WRAP_WIDTH_RST = 7'd80;
   localparam logic [COLOR_W-1:0] TEXT_COLOR_RST = 8'h61;

   localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'd32;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'd9;

   typedef enum logic [1:0] {
      SEP_NONE    = 2'd0,
      SEP_SPACE   = 2'd1,
      SEP_NEWLINE = 2'd2,
      SEP_TAB     = 2'd3
   } sep_kind_type;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_FIT  = 5'b00010,
      ST_READ = 5'b00100,
      ST_EMIT = 5'b01000,
      ST_SEP  = 5'b10000
   } wwtw_state_type;

   typedef struct packed {
      logic accept;   // take the request transaction
      logic fit;      // word fit check before a flush
      logic read;     // fetch the next stored character
      logic emit;     // load the response register and advance the cursor
      logic sep;      // apply the pending separator
   } wwtw_cmd_type;

   typedef struct packed {
      logic in_sep;
      logic in_eot;
      logic word_nonempty;
      logic last_char;
      logic out_free;
      logic sep_pending;
   } wwtw_status_type;

   function automatic sep_kind_type sep_kind(input logic [CHAR_W-1:0] c);
      sep_kind_type k;
      if (c == CHAR_SPACE) k = SEP_SPACE;
      else if (c == CHAR_NEWLINE) k = SEP_NEWLINE;
      else if (c == CHAR_TAB) k = SEP_TAB;
      else k = SEP_NONE;
      return k;
   endfunction

   function automatic logic [CHAR_W-1:0] to_screen(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] s;
      if (c >= 8'd97 && c <= 8'd122) s = c - 8'd32;
      else if (c >= 8'd65 && c <= 8'd90) s = c - 8'd64;
      else if (c >= 8'd193 && c <= 8'd218) s = c - 8'd128;
      else s = c;
      return s;
   endfunction

endpackage

`default_nettype wire

### rtl/core/wwtw_datapath.sv
// ----------------------------------------------------------------------------
// Word wrap tile writer - datapath
// Config registers, cursor, word store, flush counter and response register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "word_wrap_tile_writer_assert.svh"

module wwtw_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wr_en,
   input  logic [wwtw_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [wwtw_pkg::CSR_DATA_W-1:0]        csr_wr_data,
   input  logic [wwtw_pkg::CHAR_W-1:0]            req_char_code,
   input  logic                                   req_end_of_text,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [wwtw_pkg::ADDR_W-1:0]            rsp_vram_address,
   output logic [wwtw_pkg::CHAR_W-1:0]            rsp_screen_code,
   output logic [wwtw_pkg::COLOR_W-1:0]           rsp_attribute,
   output logic                                   rsp_last_of_word,
   input  wwtw_pkg::wwtw_cmd_type                 cmd,
   output wwtw_pkg::wwtw_status_type              status
);
   import wwtw_pkg::*;

   logic [BASE_W-1:0]  map_base_ff;
   logic [WRAP_W-1:0]  wrap_width_ff;
   logic [COLOR_W-1:0] text_color_ff;

   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [LEN_W-1:0]   word_len_ff, word_len_in;
   logic [LEN_W-1:0]   k_ff, k_in;
   sep_kind_type       sep_kind_ff;
   logic               eot_pend_ff;

   logic [CHAR_W-1:0]  word_store [MAX_WORD];
   logic [CHAR_W-1:0]  rd_data_ff;

   logic                 rsp_valid_ff;
   logic [ADDR_W-1:0]    rsp_addr_ff;
   logic [CHAR_W-1:0]    rsp_code_ff;
   logic [COLOR_W-1:0]   rsp_attr_ff;
   logic                 rsp_last_ff;

   sep_kind_type       in_kind;
   logic               store_char;
   logic               last_char;
   logic               out_free;
   logic [ADDR_LO_W-1:0] addr_lo;

   assign in_kind    = sep_kind(req_char_code);
   assign store_char = cmd.accept && (in_kind == SEP_NONE) &&
                       (word_len_ff < LEN_W'(MAX_WORD));
   assign last_char  = (k_ff + LEN_W'(1)) == word_len_ff;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   assign status.in_sep        = (in_kind != SEP_NONE);
   assign status.in_eot        = req_end_of_text;
   assign status.word_nonempty = (word_len_ff != '0);
   assign status.last_char     = last_char;
   assign status.out_free      = out_free;
   assign status.sep_pending   = (sep_kind_ff != SEP_NONE);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         map_base_ff   <= MAP_BASE_RST;
         wrap_width_ff <= WRAP_WIDTH_RST;
         text_color_ff <= TEXT_COLOR_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MAP_BASE:   map_base_ff   <= csr_wr_data[BASE_W-1:0];
            CSR_WRAP_WIDTH: wrap_width_ff <= csr_wr_data[WRAP_W-1:0];
            CSR_TEXT_COLOR: text_color_ff <= csr_wr_data[COLOR_W-1:0];
            default: ;
         endcase
      end
   end

   // cursor movement
   always_comb begin
      logic [FIT_W-1:0] fit_sum;
      logic [COL_W-1:0] col_inc;
      logic [COL_W-1:0] ww_ext;
      logic [COL_W-1:0] ww_m1;
      logic [COL_W-1:0] sep_col;
      logic [ROW_W-1:0] sep_row;
      fit_sum = {1'b0, col_ff} + FIT_W'(word_len_ff);
      col_inc = col_ff + COL_W'(1);
      ww_ext  = COL_W'(wrap_width_ff);
      ww_m1   = ww_ext - COL_W'(1);
      sep_col = col_ff;
      sep_row = row_ff;
      unique case (sep_kind_ff)
         SEP_NEWLINE: begin
            sep_col = '0;
            sep_row = row_ff + ROW_W'(1);
         end
         SEP_TAB: sep_col = col_ff + COL_W'(2);
         SEP_SPACE: begin
            if (col_ff != '0) begin
               // zero width acts as minus one: always wrap
               if (ww_ext == '0 || col_ff >= ww_m1) begin
                  sep_col = '0;
                  sep_row = row_ff + ROW_W'(1);
               end else begin
                  sep_col = col_inc;
               end
            end
         end
         default: ;
      endcase
      // empty-word fit check at end of text
      if (eot_pend_ff && sep_col > ww_ext) begin
         sep_col = '0;
         sep_row = sep_row + ROW_W'(1);
      end

      col_in = col_ff;
      row_in = row_ff;
      priority if (cmd.fit) begin
         if (fit_sum > FIT_W'(wrap_width_ff)) begin
            col_in = '0;
            row_in = row_ff + ROW_W'(1);
         end
      end else if (cmd.emit) begin
         if (col_inc == COL_W'(PRINT_COLUMNS)) begin
            col_in = '0;
            row_in = row_ff + ROW_W'(1);
         end else begin
            col_in = col_inc;
         end
      end else if (cmd.sep) begin
         col_in = sep_col;
         row_in = sep_row;
      end else begin
         col_in = col_ff;
      end
   end

   // word length and flush index
   always_comb begin
      word_len_in = word_len_ff;
      k_in        = k_ff;
      if (store_char) word_len_in = word_len_ff + LEN_W'(1);
      if (cmd.fit) k_in = '0;
      if (cmd.emit) begin
         if (last_char) begin
            word_len_in = '0;
            k_in        = '0;
         end else begin
            k_in = k_ff + LEN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         word_len_ff  <= '0;
         k_ff         <= '0;
         sep_kind_ff  <= SEP_NONE;
         eot_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         word_len_ff <= word_len_in;
         k_ff        <= k_in;
         if (cmd.accept) begin
            sep_kind_ff <= in_kind;
            eot_pend_ff <= req_end_of_text;
         end
         if (cmd.emit) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // word store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (store_char) word_store[word_len_ff[IDX_W-1:0]] <= req_char_code;
      if (cmd.read) rd_data_ff <= word_store[k_ff[IDX_W-1:0]];
   end

   assign addr_lo = ADDR_LO_W'({map_base_ff, BASE_SHIFT'(0)}) + {row_ff, 8'd0} +
                    ADDR_LO_W'({col_ff, 1'b0});

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_addr_ff <= {1'b1, addr_lo};
         rsp_code_ff <= to_screen(rd_data_ff);
         rsp_attr_ff <= text_color_ff;
         rsp_last_ff <= last_char;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_vram_address = rsp_addr_ff;
   assign rsp_screen_code  = rsp_code_ff;
   assign rsp_attribute    = rsp_attr_ff;
   assign rsp_last_of_word = rsp_last_ff;

   `WWTW_ASSERT(a_len_bound, clock, reset, word_len_ff <= LEN_W'(MAX_WORD))
   `WWTW_ASSERT(a_read_in_word, clock, reset, cmd.read |-> (k_ff < word_len_ff))
   `WWTW_ASSERT(a_last_clears, clock, reset, (cmd.emit && last_char) |=> (word_len_ff == '0 && rsp_last_ff))

endmodule

`default_nettype wire

### rtl/core/wwtw_ctrl.sv
// ----------------------------------------------------------------------------
// Word wrap tile writer - controller
// Sequences accept, fit check, store reads, emits and separator moves.
// ----------------------------------------------------------------------------
`default_nettype none
`include "word_wrap_tile_writer_assert.svh"

module wwtw_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  wwtw_pkg::wwtw_status_type  status,
   output wwtw_pkg::wwtw_cmd_type     cmd
);
   import wwtw_pkg::*;

   wwtw_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (status.in_sep) state_in = status.word_nonempty ? ST_FIT : ST_SEP;
               else if (status.in_eot) state_in = ST_FIT;
            end
         end
         ST_FIT:  state_in = ST_READ;
         ST_READ: state_in = ST_EMIT;
         ST_EMIT: begin
            // hold until the response register frees up
            if (status.out_free) begin
               if (!status.last_char) state_in = ST_READ;
               else if (status.sep_pending) state_in = ST_SEP;
               else state_in = ST_IDLE;
            end
         end
         ST_SEP:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   assign req_ready  = (state_ff == ST_IDLE);
   assign cmd.accept = (state_ff == ST_IDLE) && req_valid;
   assign cmd.fit    = (state_ff == ST_FIT);
   assign cmd.read   = (state_ff == ST_READ);
   assign cmd.emit   = (state_ff == ST_EMIT) && status.out_free;
   assign cmd.sep    = (state_ff == ST_SEP);

   `WWTW_ASSERT(a_emit_after_read, clock, reset, (state_ff == ST_EMIT) |-> ($past(state_ff) == ST_READ || $past(state_ff) == ST_EMIT))
   `WWTW_ASSERT_RST(a_reset_idle, clock, reset, state_ff == ST_IDLE)
   `WWTW_ASSERT(a_state_onehot, clock, reset, $onehot(state_ff))

endmodule

`default_nettype wire

### rtl/core/word_wrap_tile_writer.sv
// ----------------------------------------------------------------------------
// Word wrap tile writer - top level
// Greedy word wrap of a character stream onto a tile map.
// ----------------------------------------------------------------------------
// Word characters are taken one per cycle and kept in a 64-entry word store.
// A space, newline, tab or the end-of-text character flushes the stored word.
// A separator that flushes a word holds the request channel from its
// acceptance through the fit check, a word store read and a response
// register load for each stored character, and the separator's cursor
// move. An end-of-text word character needs no separator move. A
// separator with no pending word goes from its acceptance straight to
// its cursor move. The request channel stays stalled until the flush is
// done; a full response register that is not taken holds the flush.
// ----------------------------------------------------------------------------
`default_nettype none

module word_wrap_tile_writer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [wwtw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [wwtw_pkg::CSR_DATA_W-1:0]     csr_wr_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [wwtw_pkg::CHAR_W-1:0]         req_char_code,
   input  logic                                req_end_of_text,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [wwtw_pkg::ADDR_W-1:0]         rsp_vram_address,
   output logic [wwtw_pkg::CHAR_W-1:0]         rsp_screen_code,
   output logic [wwtw_pkg::COLOR_W-1:0]        rsp_attribute,
   output logic                                rsp_last_of_word
);
   import wwtw_pkg::*;

   wwtw_cmd_type    cmd;
   wwtw_status_type status;

   wwtw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   wwtw_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data),
      .req_char_code    (req_char_code),
      .req_end_of_text  (req_end_of_text),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_vram_address (rsp_vram_address),
      .rsp_screen_code  (rsp_screen_code),
      .rsp_attribute    (rsp_attribute),
      .rsp_last_of_word (rsp_last_of_word),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

`default_nettype wire

### bench/wwtw_tile_write_check.sv
// ----------------------------------------------------------------------------
// Word wrap tile writer - tile write checker
// Watches the request, response and register ports, lays out each accepted
// character with its own cursor and word buffer, and compares every response
// transaction field by field with the oldest predicted tile write.
// ----------------------------------------------------------------------------

module wwtw_tile_write_check (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [wwtw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [wwtw_pkg::CSR_DATA_W-1:0]     csr_wr_data,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [wwtw_pkg::CHAR_W-1:0]         req_char_code,
   input  logic                                req_end_of_text,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [wwtw_pkg::ADDR_W-1:0]         rsp_vram_address,
   input  logic [wwtw_pkg::CHAR_W-1:0]         rsp_screen_code,
   input  logic [wwtw_pkg::COLOR_W-1:0]        rsp_attribute,
   input  logic                                rsp_last_of_word,
   output int                                  mismatch_count,
   output int                                  writes_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import wwtw_pkg::*;

   typedef struct packed {
      logic [ADDR_W-1:0]  address;
      logic [CHAR_W-1:0]  code;
      logic [COLOR_W-1:0] color;
      logic               word_end;
   } tile_write_type;

   tile_write_type expected_writes[$];

   logic [BASE_W-1:0]  map_base;
   logic [WRAP_W-1:0]  wrap_width;
   logic [COLOR_W-1:0] text_color;

   logic [COL_W-1:0]   column;
   logic [ROW_W-1:0]   row;
   logic [CHAR_W-1:0]  word_buf [MAX_WORD];
   int                 word_len;

   function automatic logic [CHAR_W-1:0] tile_code_of(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] offset;
      offset = '0;
      if (c >= 8'd97 && c <= 8'd122) offset = 8'd32;
      else if (c >= 8'd65 && c <= 8'd90) offset = 8'd64;
      else if (c >= 8'd193 && c <= 8'd218) offset = 8'd128;
      return c - offset;
   endfunction

   task automatic new_line();
      column = '0;
      row = row + 8'd1;
   endtask

   // signed compare: a zero wrap width still pushes any word past column 0
   task automatic fit_word(input int len);
      if (int'(column) + len > int'(wrap_width)) new_line();
   endtask

   task automatic flush_word();
      tile_write_type w;
      logic [ADDR_LO_W-1:0] lo;
      fit_word(word_len);
      for (int k = 0; k < word_len; k++) begin
         lo = {map_base[6:0], 9'b0} + {row, 8'b0} + {7'b0, column, 1'b0};
         w.address = {1'b1, lo};
         w.code = tile_code_of(word_buf[k]);
         w.color = text_color;
         w.word_end = (k == word_len - 1);
         expected_writes.push_back(w);
         column = column + 8'd1;
         if (column == COL_W'(PRINT_COLUMNS)) new_line();
      end
      word_len = 0;
   endtask

   task automatic lay_out_char(input logic [CHAR_W-1:0] c, input logic eot);
      if (c == CHAR_SPACE || c == CHAR_NEWLINE || c == CHAR_TAB) begin
         if (word_len > 0) flush_word();
         if (c == CHAR_NEWLINE) begin
            new_line();
         end else if (c == CHAR_TAB) begin
            column = column + 8'd2;
         end else if (column != 0) begin
            if (int'(column) >= int'(wrap_width) - 1) new_line();
            else column = column + 8'd1;
         end
         if (eot) fit_word(0);
      end else begin
         // drop characters once the word buffer is full
         if (word_len < MAX_WORD) begin
            word_buf[word_len] = c;
            word_len++;
         end
         if (eot) flush_word();
      end
   endtask

   task automatic compare_write(input tile_write_type got);
      tile_write_type want;
      if (expected_writes.size() == 0) begin
         $display("%0t: unexpected tile write addr %h code %h attr %h last %b",
                  $realtime, got.address, got.code, got.color, got.word_end);
         mismatch_count++;
      end else begin
         want = expected_writes.pop_front();
         if (got.address !== want.address) begin
            $display("%0t: vram_address expected %h actual %h",
                     $realtime, want.address, got.address);
            mismatch_count++;
         end
         if (got.code !== want.code) begin
            $display("%0t: screen_code expected %h actual %h",
                     $realtime, want.code, got.code);
            mismatch_count++;
         end
         if (got.color !== want.color) begin
            $display("%0t: attribute expected %h actual %h",
                     $realtime, want.color, got.color);
            mismatch_count++;
         end
         if (got.word_end !== want.word_end) begin
            $display("%0t: last_of_word expected %b actual %b",
                     $realtime, want.word_end, got.word_end);
            mismatch_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         map_base = MAP_BASE_RST;
         wrap_width = WRAP_WIDTH_RST;
         text_color = TEXT_COLOR_RST;
         column = '0;
         row = '0;
         word_len = 0;
         expected_writes.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_MAP_BASE:   map_base = csr_wr_data[BASE_W-1:0];
               CSR_WRAP_WIDTH: wrap_width = csr_wr_data[WRAP_W-1:0];
               CSR_TEXT_COLOR: text_color = csr_wr_data[COLOR_W-1:0];
               default: ;
            endcase
         end
         // responses at this edge belong to earlier requests: check them first
         if (rsp_valid && rsp_ready)
            compare_write({rsp_vram_address, rsp_screen_code, rsp_attribute,
                           rsp_last_of_word});
         if (req_valid && req_ready) lay_out_char(req_char_code, req_end_of_text);
      end
      writes_pending = expected_writes.size();
   end

endmodule

### bench/word_wrap_tile_writer_test.sv
// ----------------------------------------------------------------------------
// Word wrap tile writer - testbench top
// Feeds directed and random text through the writer under several register
// settings, with random gaps on both channels outside the quiet phase; the checker scores the tile
// writes and this module gives the verdict.
// ----------------------------------------------------------------------------

module word_wrap_tile_writer_test;
   timeunit 1ns;
   timeprecision 1ps;

   import wwtw_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;   // decodes to nothing
   localparam int IDLE_PCT    = 27;
   localparam int DRAIN_TICKS = 10;

   localparam logic [8:0] OPENING_TEXT [25] = '{
      {1'b0, CHAR_SPACE},            // space at column 0
      9'd97, 9'd122, 9'd65, 9'd90, 9'd193, 9'd218,
      9'd0, 9'd255, 9'd96, 9'd123, 9'd64, 9'd91, 9'd192, 9'd219,
      {1'b0, CHAR_SPACE},
      {1'b0, CHAR_TAB},
      9'd113,
      {1'b0, CHAR_NEWLINE},
      9'd120,
      {1'b1, 8'd121},                // end of text on a word character
      9'd119,
      {1'b1, CHAR_SPACE},            // end of text on a separator
      {1'b1, CHAR_TAB},
      {1'b0, CHAR_NEWLINE}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = CSR_MAP_BASE;
   logic [CSR_DATA_W-1:0]  csr_wr_data = '0;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [CHAR_W-1:0]      req_char_code = '0;
   logic                   req_end_of_text = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [ADDR_W-1:0]      rsp_vram_address;
   logic [CHAR_W-1:0]      rsp_screen_code;
   logic [COLOR_W-1:0]     rsp_attribute;
   logic                   rsp_last_of_word;

   int   mismatch_count;
   int   writes_pending;
   int   chars_sent = 0;
   logic steady = 1'b0;

   word_wrap_tile_writer dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_code    (req_char_code),
      .req_end_of_text  (req_end_of_text),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_vram_address (rsp_vram_address),
      .rsp_screen_code  (rsp_screen_code),
      .rsp_attribute    (rsp_attribute),
      .rsp_last_of_word (rsp_last_of_word)
   );

   wwtw_tile_write_check write_check (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_code    (req_char_code),
      .req_end_of_text  (req_end_of_text),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_vram_address (rsp_vram_address),
      .rsp_screen_code  (rsp_screen_code),
      .rsp_attribute    (rsp_attribute),
      .rsp_last_of_word (rsp_last_of_word),
      .mismatch_count   (mismatch_count),
      .writes_pending   (writes_pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready <= steady ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
   end

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // hold valid and payload until the transaction is taken
   task automatic send_char(input logic [CHAR_W-1:0] c, input logic eot);
      @(negedge clock);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_char_code <= c;
      req_end_of_text <= eot;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      chars_sent++;
   endtask

   // drop valid, let the last flush finish and the separator settle
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (writes_pending != 0) @(negedge clock);
      repeat (DRAIN_TICKS) @(negedge clock);
   endtask

   task automatic send_random_text(input int count);
      int target, pick, len;
      logic word_eot;
      logic [CHAR_W-1:0] c, sep;
      target = chars_sent + count;
      while (chars_sent < target) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            send_char(8'($urandom_range(255)), 1'($urandom_range(1)));
         end else if (pick < 15) begin
            // tab runs can push the cursor past the print columns
            repeat ($urandom_range(1, 6)) send_char(CHAR_TAB, 1'b0);
         end else begin
            pick = $urandom_range(99);
            if (pick < 85) len = $urandom_range(1, 10);
            else if (pick < 95) len = $urandom_range(11, 40);
            else len = $urandom_range(60, 70);
            word_eot = ($urandom_range(9) == 0);
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(9) < 7)
                  c = ($urandom_range(1) ? 8'd97 : 8'd65) + 8'($urandom_range(25));
               else
                  c = 8'($urandom_range(255));
               send_char(c, word_eot && (i == len - 1));
            end
            if (!word_eot) begin
               pick = $urandom_range(9);
               if (pick < 7) sep = CHAR_SPACE;
               else if (pick < 8) sep = CHAR_NEWLINE;
               else if (pick < 9) sep = CHAR_TAB;
               else begin
                  send_char(CHAR_SPACE, 1'b0);
                  sep = CHAR_SPACE;
               end
               send_char(sep, $urandom_range(19) == 0);
            end
         end
      end
   endtask

   task automatic run_phase(input logic [CSR_DATA_W-1:0] base,
                            input logic [CSR_DATA_W-1:0] wrap,
                            input logic [CSR_DATA_W-1:0] color,
                            input int count, input logic quiet);
      csr_write(CSR_MAP_BASE, base);
      csr_write(CSR_WRAP_WIDTH, wrap);
      csr_write(CSR_TEXT_COLOR, color);
      steady = quiet;
      send_random_text(count);
      drain();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (OPENING_TEXT[i]) send_char(OPENING_TEXT[i][7:0], OPENING_TEXT[i][8]);
      drain();

      run_phase(8'hFF, 8'd1, 8'h00, 40, 1'b0);
      run_phase(8'h80, 8'h7F, 8'hFF, 40, 1'b1);
      // bit 7 of the wrap write is masked off, leaving a zero wrap width
      csr_write(CSR_SPARE, 8'($urandom_range(255)));
      run_phase(8'($urandom_range(255)), 8'h80, 8'($urandom_range(255)), 30, 1'b0);
      run_phase(8'h00, 8'hD0, 8'($urandom_range(255)), 45, 1'b0);
      run_phase(8'($urandom_range(255)), 8'($urandom_range(2, 79)),
                8'($urandom_range(255)), 40, 1'b0);

      if (mismatch_count == 0 && writes_pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
